/* rtl/assert_macros.svh */
// Assertion macros used by the double-ended queue control.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge outside reset.
`define DEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: the consequent holds in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/deq_pkg.sv */
// Package for the double-ended queue: operation codes, word width and default depth.
// Depends on nothing; imported by every module of the block.
package deq_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned OP_W      = 3;
	localparam int unsigned DEPTH_DEF = 1024;

	// Word returned when nothing is popped or peeked.
	localparam logic [WORD_W-1:0] NONE_WORD = '1;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5,
		OP_QUERY      = 3'd6
	} op_t;

endpackage

/* rtl/deq_ctrl.sv */
// Ring buffer control: front pointer, occupancy and the memory request for each command.
// Depends on deq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module deq_ctrl #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [deq_pkg::OP_W-1:0]          op,
	input  logic [deq_pkg::WORD_W-1:0]        value,
	output logic                              mem_we,
	output logic                              mem_re,
	output logic [$clog2(DEPTH)-1:0]          mem_addr,
	output logic [deq_pkg::WORD_W-1:0]        mem_wdata,
	output logic [$clog2(DEPTH+1)-1:0]        count_nx,
	output logic                              refused
);
	import deq_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = IW + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	logic [IW-1:0] front_q;
	logic [CW-1:0] occ_q;
	logic [IW-1:0] front_nx;
	logic [IW-1:0] front_dec;
	logic [IW-1:0] front_inc;
	logic [IW-1:0] tail_idx;
	logic [IW-1:0] last_idx;
	logic [SW-1:0] tail_sum;
	logic [SW-1:0] last_sum;
	logic          full;
	logic          empty;

	// Fold a sum below twice the depth back into the ring.
	function automatic logic [IW-1:0] wrap(input logic [SW-1:0] x);
		logic [SW-1:0] y;
		y = (x >= DEPTH_S) ? (x - DEPTH_S) : x;
		return y[IW-1:0];
	endfunction

	// Slot arithmetic around the current front.
	assign full      = (occ_q == DEPTH_C);
	assign empty     = (occ_q == '0);
	assign front_dec = (front_q == '0) ? LAST_IDX : (front_q - IW'(1));
	assign front_inc = (front_q == LAST_IDX) ? '0 : (front_q + IW'(1));
	assign tail_sum  = SW'(front_q) + SW'(occ_q);
	assign last_sum  = tail_sum - SW'(1);
	assign tail_idx  = wrap(tail_sum);
	assign last_idx  = wrap(last_sum);
	assign mem_wdata = value;

	// Decode the command into at most one memory access and the next pointer state.
	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = front_q;
		front_nx = front_q;
		count_nx = occ_q;
		refused  = 1'b0;
		case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					refused = 1'b1;
				end else begin
					mem_we   = 1'b1;
					mem_addr = front_dec;
					front_nx = front_dec;
					count_nx = occ_q + CW'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					refused = 1'b1;
				end else begin
					mem_we   = 1'b1;
					mem_addr = tail_idx;
					count_nx = occ_q + CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (!empty) begin
					mem_re   = 1'b1;
					mem_addr = front_q;
					front_nx = front_inc;
					count_nx = occ_q - CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (!empty) begin
					mem_re   = 1'b1;
					mem_addr = last_idx;
					count_nx = occ_q - CW'(1);
				end
			end
			OP_PEEK_FRONT: begin
				mem_re   = !empty;
				mem_addr = front_q;
			end
			OP_PEEK_BACK: begin
				mem_re   = !empty;
				mem_addr = last_idx;
			end
			default: begin
			end
		endcase
		if (!accept) begin
			mem_we   = 1'b0;
			mem_re   = 1'b0;
			front_nx = front_q;
			count_nx = occ_q;
		end
	end

	// Pointer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q   <= '0;
		end else begin
			front_q <= front_nx;
			occ_q   <= count_nx;
		end
	end

	`DEQ_ASSERT(a_occ_bound, clk, arst_n, occ_q <= DEPTH_C, "occupancy beyond depth")
	`DEQ_ASSERT(a_front_bound, clk, arst_n, SW'(front_q) < DEPTH_S, "front index outside ring")
	`DEQ_ASSERT_NEXT(a_pop_dec, clk, arst_n,
		accept && !empty && (op == OP_POP_FRONT || op == OP_POP_BACK),
		occ_q == $past(occ_q) - CW'(1), "pop did not lower occupancy")
	`DEQ_ASSERT(a_refuse_full, clk, arst_n, !refused || full, "push refused while not full")

endmodule

/* rtl/deq_ram.sv */
// Single-port storage for the ring buffer, one write or one registered read per cycle.
// Depends on deq_pkg for the word width.
module deq_ram #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  logic [deq_pkg::WORD_W-1:0] wdata,
	output logic [deq_pkg::WORD_W-1:0] rdata
);
	import deq_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/double_ended_queue.sv */
// Double-ended queue of 32-bit words on a ring buffer of DEPTH entries.
// A command gives its result, with done high, in the cycle after it is taken.
// Throughput: one command per cycle unless busy; the single RAM port serves one push or read.
// Reset: asynchronous, active low; the queue comes up empty and busy is high for one cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
module double_ended_queue #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [deq_pkg::OP_W-1:0]          op,
	input  logic signed [deq_pkg::WORD_W-1:0] value,
	output logic                              done,
	output logic signed [deq_pkg::WORD_W-1:0] word,
	output logic [$clog2(DEPTH+1)-1:0]        count,
	output logic                              empty_res,
	output logic                              push_refused
);
	import deq_pkg::*;

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic              accept;
	logic              busy_q;
	logic              mem_we;
	logic              mem_re;
	logic [IW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_wdata;
	logic [WORD_W-1:0] mem_rdata;
	logic [CW-1:0]     count_nx;
	logic              refused;
	logic              done_s1;
	logic              hit_s1;
	logic [CW-1:0]     count_s1;
	logic              refused_s1;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op),
		.value     (value),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.count_nx  (count_nx),
		.refused   (refused)
	);

	deq_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Busy for the first cycle out of reset only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Result stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1     <= mem_re;
			count_s1   <= count_nx;
			refused_s1 <= refused;
		end
	end

	// A read beat returns the stored word; anything else returns all ones.
	assign done         = done_s1;
	assign word         = hit_s1 ? mem_rdata : NONE_WORD;
	assign count        = count_s1;
	assign empty_res    = (count_s1 == '0);
	assign push_refused = refused_s1;

endmodule

/* verif/deq_checker.sv */
// Checker for the double-ended queue: watches command and result beats, predicts each result.
// Depends on deq_pkg for the operation codes, the word width and the empty-answer word.
module deq_checker #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [deq_pkg::OP_W-1:0]          op,
	input  logic signed [deq_pkg::WORD_W-1:0] value,
	input  logic                              done,
	input  logic signed [deq_pkg::WORD_W-1:0] word,
	input  logic [$clog2(DEPTH+1)-1:0]        count,
	input  logic                              empty_res,
	input  logic                              push_refused,
	output int                                fail_count,
	output int                                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	typedef struct {
		logic [WORD_W-1:0] word;
		logic [CNT_W-1:0]  count;
		logic              empty;
		logic              refused;
	} deq_result_t;

	// Own copy of the ring buffer.
	logic [WORD_W-1:0] ring [DEPTH];
	int unsigned       head;
	int unsigned       fill;
	deq_result_t       awaited[$];

	// Applies one command to the ring copy and returns the result it should give.
	function automatic deq_result_t apply_command(logic [OP_W-1:0] cmd, logic [WORD_W-1:0] din);
		deq_result_t res;
		res.word    = NONE_WORD;
		res.refused = 1'b0;
		case (cmd)
			OP_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					res.refused = 1'b1;
				end else begin
					head       = (head + DEPTH - 1) % DEPTH;
					ring[head] = din;
					fill++;
				end
			end
			OP_PUSH_BACK: begin
				if (fill >= DEPTH) begin
					res.refused = 1'b1;
				end else begin
					ring[(head + fill) % DEPTH] = din;
					fill++;
				end
			end
			OP_POP_FRONT: begin
				if (fill != 0) begin
					res.word = ring[head];
					head     = (head + 1) % DEPTH;
					fill--;
				end
			end
			OP_POP_BACK: begin
				if (fill != 0) begin
					res.word = ring[(head + fill - 1) % DEPTH];
					fill--;
				end
			end
			OP_PEEK_FRONT: begin
				if (fill != 0)
					res.word = ring[head];
			end
			OP_PEEK_BACK: begin
				if (fill != 0)
					res.word = ring[(head + fill - 1) % DEPTH];
			end
			default: begin
			end
		endcase
		res.count = CNT_W'(fill);
		res.empty = (fill == 0);
		return res;
	endfunction

	// One line per mismatch; printing is capped so a broken block cannot flood the log.
	task automatic report_mismatch(string msg);
		if (fail_count < 100)
			$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// Result beats are checked against the oldest prediction, then the command beat is taken.
	always @(posedge clk or negedge arst_n) begin
		deq_result_t exp_res;
		if (!arst_n) begin
			head        = 0;
			fill        = 0;
			fail_count  = 0;
			outstanding = 0;
			awaited.delete();
		end else begin
			if (done === 1'b1) begin
				if (awaited.size() == 0) begin
					report_mismatch("result beat with no command waiting");
				end else begin
					exp_res = awaited.pop_front();
					if (word !== exp_res.word)
						report_mismatch($sformatf("word %h, expected %h", word, exp_res.word));
					if (count !== exp_res.count)
						report_mismatch($sformatf("count %0d, expected %0d", count,
							exp_res.count));
					if (empty_res !== exp_res.empty)
						report_mismatch($sformatf("empty_res %b, expected %b", empty_res,
							exp_res.empty));
					if (push_refused !== exp_res.refused)
						report_mismatch($sformatf("push_refused %b, expected %b",
							push_refused, exp_res.refused));
				end
			end else if (done !== 1'b0) begin
				report_mismatch("done is unknown");
			end
			if (start && busy === 1'b0)
				awaited.push_back(apply_command(op, value));
			outstanding = awaited.size();
		end
	end

endmodule

/* verif/testbench.sv */
// Top of the double-ended queue testbench: clock, reset, command stimulus and the verdict.
// Depends on deq_pkg, the double_ended_queue block and the deq_checker module.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int unsigned DEPTH = DEPTH_DEF;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	// Code outside the defined set; the block must treat it as a query.
	localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [OP_W-1:0]          op;
	logic signed [WORD_W-1:0] value;
	logic                     done;
	logic signed [WORD_W-1:0] word;
	logic [CNT_W-1:0]         count;
	logic                     empty_res;
	logic                     push_refused;
	int                       fail_count;
	int                       outstanding;

	// Entries held, tracked only to steer the stimulus.
	int                       level;
	int                       calm_left;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	double_ended_queue #(.DEPTH(DEPTH)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.value        (value),
		.done         (done),
		.word         (word),
		.count        (count),
		.empty_res    (empty_res),
		.push_refused (push_refused)
	);

	deq_checker #(.DEPTH(DEPTH)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.value        (value),
		.done         (done),
		.word         (word),
		.count        (count),
		.empty_res    (empty_res),
		.push_refused (push_refused),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	// Words lean towards the extremes now and then.
	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return NONE_WORD;
			3:       return '0;
			default: return $urandom();
		endcase
	endfunction

	// Picks an operation with the given share of pushes and pops, in percent.
	function automatic logic [OP_W-1:0] pick_op(int push_pct, int pop_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < push_pct)
			return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		if (roll < push_pct + pop_pct)
			return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
		case ($urandom_range(0, 9))
			8:       return OP_QUERY;
			9:       return OP_SPARE;
			default: return $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
		endcase
	endfunction

	// Drives one command beat from a falling edge and returns at the falling edge after
	// it is taken, with start still high so that back-to-back beats need no lowering.
	task automatic send_cmd(logic [OP_W-1:0] cmd, logic [WORD_W-1:0] din);
		int gap;
		if (calm_left > 0) begin
			gap = 0;
			calm_left--;
		end else begin
			if ($urandom_range(0, 15) == 0)
				calm_left = $urandom_range(8, 40);
			gap = $urandom_range(0, 6);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		op    <= cmd;
		value <= din;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if ((cmd == OP_PUSH_FRONT || cmd == OP_PUSH_BACK) && level < DEPTH)
			level++;
		else if ((cmd == OP_POP_FRONT || cmd == OP_POP_BACK) && level > 0)
			level--;
		@(negedge clk);
	endtask

	task automatic send_random(int push_pct, int pop_pct);
		send_cmd(pick_op(push_pct, pop_pct), rand_word());
	endtask

	// Stimulus: directed cases, a mixed random walk, a drain to empty
	// and a random walk near empty.
	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		op        = OP_QUERY;
		value     = '0;
		level     = 0;
		calm_left = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reads and queries on an empty queue, including the spare code.
		send_cmd(OP_POP_FRONT, '0);
		send_cmd(OP_POP_BACK, '0);
		send_cmd(OP_PEEK_FRONT, '0);
		send_cmd(OP_PEEK_BACK, '0);
		send_cmd(OP_QUERY, '0);
		send_cmd(OP_SPARE, '0);
		// Extreme words at both ends, and a stored all-ones word.
		send_cmd(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		send_cmd(OP_PUSH_BACK, 32'h8000_0000);
		send_cmd(OP_PUSH_BACK, NONE_WORD);
		send_cmd(OP_PUSH_FRONT, '0);
		send_cmd(OP_PUSH_BACK, 32'h5555_5555);
		send_cmd(OP_PUSH_FRONT, 32'hAAAA_AAAA);
		send_cmd(OP_PEEK_FRONT, '0);
		send_cmd(OP_PEEK_BACK, '0);
		send_cmd(OP_POP_BACK, '0);
		send_cmd(OP_POP_BACK, '0);
		send_cmd(OP_SPARE, 32'hFFFF_FFFF);
		send_cmd(OP_POP_FRONT, '0);
		send_cmd(OP_POP_FRONT, '0);
		send_cmd(OP_POP_BACK, '0);
		send_cmd(OP_POP_FRONT, '0);
		send_cmd(OP_QUERY, '0);

		// Mixed traffic with a slight lean towards pushes.
		repeat (360)
			send_random(45, 40);

		// Drain, then reads on the empty queue and a walk around empty.
		while (level > 0)
			send_random(5, 85);
		send_cmd(OP_POP_FRONT, '0);
		send_cmd(OP_PEEK_BACK, '0);
		repeat (40)
			send_random(45, 40);
		start <= 1'b0;

		// Let every predicted result arrive, then a few spare cycles.
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (fail_count == 0)
			$display("double_ended_queue verification clean");
		else
			$display("double_ended_queue verification failed");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#(12 * 200000);
		$display("double_ended_queue verification failed");
		$finish;
	end

endmodule
